@@ hw/rtl/bptc_pkg.sv @@
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RawW  = 20;
  localparam int NumW  = 64;   // numerator / quotient width of the divider
  localparam int DenW  = 32;   // divisor magnitude width (divisor is 31-bit signed)
  localparam int TempW = 15;

  localparam logic signed [31:0] FineOffset = 32'sd128000;
  localparam logic signed [27:0] TempLo     = -28'sd4000;
  localparam logic signed [27:0] TempHi     = 28'sd8500;

  typedef enum logic [1:0] {
    CFG_TEMP      = 2'd0,
    CFG_PRES_LO   = 2'd1,
    CFG_PRES_HI   = 2'd2,
    CFG_PRES_LAST = 2'd3
  } cfg_addr_t;

  // side data that travels with an item through the divider
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [31:0]      fine;
    logic                    err;
    logic                    neg;
  } tag_t;

endpackage

@@ hw/rtl/bptc_div.sv @@
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// ----------------------------------------------------------------------------
module bptc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [bptc_pkg::NumW-1:0]  in_num,
  input  logic [bptc_pkg::DenW-1:0]  in_den,
  input  bptc_pkg::tag_t             in_tag,
  output logic                       out_vld,
  output logic [bptc_pkg::NumW-1:0]  out_quo,
  output bptc_pkg::tag_t             out_tag
);

  localparam int N = bptc_pkg::NumW;
  localparam int D = bptc_pkg::DenW;

  logic [D-1:0]    rem_r [N];
  logic [N-1:0]    dvd_r [N];
  logic [D-1:0]    den_r [N];
  bptc_pkg::tag_t  tag_r [N];
  logic [N-1:0]    vld_r;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      logic [D-1:0]   rem_src;
      logic [N-1:0]   dvd_src;
      logic [D-1:0]   den_src;
      bptc_pkg::tag_t tag_src;
      logic           vld_src;
      logic [D:0]     trial;
      logic [D:0]     diff;
      logic           ge;
      logic [D-1:0]   rem_nxt;
      logic [N-1:0]   dvd_nxt;

      if (g == 0) begin : g_first
        assign rem_src = '0;
        assign dvd_src = in_num;
        assign den_src = in_den;
        assign tag_src = in_tag;
        assign vld_src = in_vld;
      end else begin : g_next
        assign rem_src = rem_r[g-1];
        assign dvd_src = dvd_r[g-1];
        assign den_src = den_r[g-1];
        assign tag_src = tag_r[g-1];
        assign vld_src = vld_r[g-1];
      end

      assign trial   = {rem_src, dvd_src[N-1]};
      assign ge      = trial >= {1'b0, den_src};
      assign diff    = trial - {1'b0, den_src};
      assign rem_nxt = ge ? diff[D-1:0] : trial[D-1:0];
      assign dvd_nxt = {dvd_src[N-2:0], ge};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (en) begin
          vld_r[g] <= vld_src;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_nxt;
          dvd_r[g] <= dvd_nxt;
          den_r[g] <= den_src;
          tag_r[g] <= tag_src;
        end
      end
    end
  endgenerate

  assign out_vld = vld_r[N-1];
  assign out_quo = dvd_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

@@ hw/rtl/baro_pressure_temp_compensation_top.sv @@
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Integer compensation of raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless the output is stalled and returns one
// result per input item, in order, through 13 stages of temperature and
// divisor arithmetic, a 64-stage divider that settles one quotient bit per
// stage, 6 stages of pressure correction and the output register. The whole
// pipeline holds while a result waits on out_tready. Calibration words must be
// written through cfg_* while no item is in flight; the block does not enforce it.
module baro_pressure_temp_compensation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [19:0] raw_pressure, [39:20] raw_temperature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [14:0] temperature_centi, [46:15] fine_temperature,
                                  // [78:47] pressure_q24_8, [79] zero
  output logic        out_tuser,  // [0] divide_error
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  // ---------------- configuration ----------------
  logic [47:0] temp_cal_r;
  logic [63:0] pcal_lo_r;
  logic [63:0] pcal_hi_r;
  logic [15:0] pcal_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r  <= '0;
      pcal_lo_r   <= '0;
      pcal_hi_r   <= '0;
      pcal_last_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (bptc_pkg::cfg_addr_t'(cfg_addr))
        bptc_pkg::CFG_TEMP:      temp_cal_r  <= cfg_wdata[47:0];
        bptc_pkg::CFG_PRES_LO:   pcal_lo_r   <= cfg_wdata;
        bptc_pkg::CFG_PRES_HI:   pcal_hi_r   <= cfg_wdata;
        bptc_pkg::CFG_PRES_LAST: pcal_last_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0]        p3x, p6x, p8x, p9x;  // sign-extended for high-half products

  assign t1  = temp_cal_r[15:0];
  assign t2  = $signed(temp_cal_r[31:16]);
  assign t3  = $signed(temp_cal_r[47:32]);
  assign p1  = pcal_lo_r[15:0];
  assign p2  = $signed(pcal_lo_r[31:16]);
  assign p3  = $signed(pcal_lo_r[47:32]);
  assign p4  = $signed(pcal_lo_r[63:48]);
  assign p5  = $signed(pcal_hi_r[15:0]);
  assign p6  = $signed(pcal_hi_r[31:16]);
  assign p7  = $signed(pcal_hi_r[47:32]);
  assign p8  = $signed(pcal_hi_r[63:48]);
  assign p9  = $signed(pcal_last_r);
  assign p3x = {{16{p3[15]}}, p3};
  assign p6x = {{16{p6[15]}}, p6};
  assign p8x = {{16{p8[15]}}, p8};
  assign p9x = {{16{p9[15]}}, p9};

  // ---------------- flow control ----------------
  logic en;
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // ---------------- front stages ----------------
  logic [13:1] fv_r;

  logic [bptc_pkg::RawW-1:0] adc_p, adc_t;
  assign adc_p = in_tdata[19:0];
  assign adc_t = in_tdata[39:20];

  logic signed [17:0] s1_d1_r;
  logic signed [16:0] s1_d2_r;
  logic [20:0]        s1_pr_r;
  logic signed [33:0] s2_m1_r, s2_m2_r;
  logic [20:0]        s2_pr_r;
  logic signed [22:0] s3_a_r;
  logic signed [37:0] s3_m3_r;
  logic [20:0]        s3_pr_r;
  logic signed [31:0] s4_fine_r;
  logic [20:0]        s4_pr_r;
  logic signed [31:0] s5_fa_r;
  bptc_pkg::tag_t     s5_tag_r;
  logic [20:0]        s5_pr_r;
  logic signed [63:0] s6_aa_r;
  logic signed [47:0] s6_ap5_r, s6_ap2_r;
  bptc_pkg::tag_t     s6_tag_r;
  logic [20:0]        s6_pr_r;
  logic signed [48:0] s7_l6_r, s7_l3_r;
  logic [31:0]        s7_h6_r, s7_h3_r;
  logic signed [47:0] s7_ap5_r, s7_ap2_r;
  bptc_pkg::tag_t     s7_tag_r;
  logic [20:0]        s7_pr_r;
  logic [63:0]        s8_b6_r, s8_b3_r;
  logic signed [47:0] s8_ap5_r, s8_ap2_r;
  bptc_pkg::tag_t     s8_tag_r;
  logic [20:0]        s8_pr_r;
  logic [63:0]        s9_b_r, s9_a_r;
  bptc_pkg::tag_t     s9_tag_r;
  logic [20:0]        s9_pr_r;
  logic [47:0]        s10_vl_r;
  logic [31:0]        s10_vh_r;
  logic [63:0]        s10_n0_r;
  bptc_pkg::tag_t     s10_tag_r;
  logic signed [30:0] s11_den_r;
  logic [43:0]        s11_nl_r;
  logic [31:0]        s11_nh_r;
  bptc_pkg::tag_t     s11_tag_r;
  logic [63:0]        s12_num_r;
  logic signed [30:0] s12_den_r;
  bptc_pkg::tag_t     s12_tag_r;
  logic [63:0]        s13_an_r;
  logic [31:0]        s13_ad_r;
  bptc_pkg::tag_t     s13_tag_r;

  // combinational helpers
  logic signed [35:0] t5x;
  logic signed [27:0] t5;
  logic signed [27:0] t5c;
  logic [63:0]        v10;
  logic [63:0]        prod11;
  logic signed [31:0] den13;
  bptc_pkg::tag_t     tag5, tag12, tag13;

  always_comb begin
    t5x = (36'(s4_fine_r) <<< 2) + 36'(s4_fine_r) + 36'sd128;
    t5  = $signed(t5x[35:8]);
    if (t5 < bptc_pkg::TempLo) begin
      t5c = bptc_pkg::TempLo;
    end else if (t5 > bptc_pkg::TempHi) begin
      t5c = bptc_pkg::TempHi;
    end else begin
      t5c = t5;
    end
    tag5      = '0;
    tag5.temp = $signed(t5c[bptc_pkg::TempW-1:0]);
    tag5.fine = s4_fine_r;

    v10    = 64'h0000_8000_0000_0000 + s9_a_r;
    prod11 = 64'(s10_vl_r) + {s10_vh_r, 32'b0};

    tag12     = s11_tag_r;
    tag12.err = (s11_den_r == '0);

    den13     = 32'(s12_den_r);
    tag13     = s12_tag_r;
    tag13.neg = s12_num_r[63] ^ den13[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[12:1], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S1: offsets from T1
      s1_d1_r <= $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_d2_r <= $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});
      s1_pr_r <= 21'h10_0000 - {1'b0, adc_p};
      // S2
      s2_m1_r <= s1_d1_r * t2;
      s2_m2_r <= s1_d2_r * s1_d2_r;
      s2_pr_r <= s1_pr_r;
      // S3
      s3_a_r  <= $signed(s2_m1_r[33:11]);
      s3_m3_r <= $signed(s2_m2_r[33:12]) * t3;
      s3_pr_r <= s2_pr_r;
      // S4: fine temperature
      s4_fine_r <= 32'(s3_a_r) + 32'($signed(s3_m3_r[37:14]));
      s4_pr_r   <= s3_pr_r;
      // S5: centi-degrees, pressure offset
      s5_fa_r  <= s4_fine_r - bptc_pkg::FineOffset;
      s5_tag_r <= tag5;
      s5_pr_r  <= s4_pr_r;
      // S6
      s6_aa_r  <= s5_fa_r * s5_fa_r;
      s6_ap5_r <= s5_fa_r * p5;
      s6_ap2_r <= s5_fa_r * p2;
      s6_tag_r <= s5_tag_r;
      s6_pr_r  <= s5_pr_r;
      // S7: a*a times P6 and P3, split in 32-bit halves
      s7_l6_r  <= $signed({1'b0, s6_aa_r[31:0]}) * p6;
      s7_h6_r  <= 32'(s6_aa_r[63:32] * p6x);
      s7_l3_r  <= $signed({1'b0, s6_aa_r[31:0]}) * p3;
      s7_h3_r  <= 32'(s6_aa_r[63:32] * p3x);
      s7_ap5_r <= s6_ap5_r;
      s7_ap2_r <= s6_ap2_r;
      s7_tag_r <= s6_tag_r;
      s7_pr_r  <= s6_pr_r;
      // S8
      s8_b6_r  <= 64'(s7_l6_r) + {s7_h6_r, 32'b0};
      s8_b3_r  <= 64'(s7_l3_r) + {s7_h3_r, 32'b0};
      s8_ap5_r <= s7_ap5_r;
      s8_ap2_r <= s7_ap2_r;
      s8_tag_r <= s7_tag_r;
      s8_pr_r  <= s7_pr_r;
      // S9
      s9_b_r   <= s8_b6_r + (64'(s8_ap5_r) << 17) + (64'(p4) << 35);
      s9_a_r   <= 64'($signed(s8_b3_r[63:8])) + (64'(s8_ap2_r) << 12);
      s9_tag_r <= s8_tag_r;
      s9_pr_r  <= s8_pr_r;
      // S10: (2^47 + a) * P1 halves, numerator base
      s10_vl_r  <= v10[31:0] * p1;
      s10_vh_r  <= 32'(v10[63:32] * p1);
      s10_n0_r  <= 64'({s9_pr_r, 31'b0}) - s9_b_r;
      s10_tag_r <= s9_tag_r;
      // S11: divisor, numerator * 3125 halves
      s11_den_r <= $signed(prod11[63:33]);
      s11_nl_r  <= s10_n0_r[31:0] * 12'd3125;
      s11_nh_r  <= 32'(s10_n0_r[63:32] * 12'd3125);
      s11_tag_r <= s10_tag_r;
      // S12
      s12_num_r <= 64'(s11_nl_r) + {s11_nh_r, 32'b0};
      s12_den_r <= s11_den_r;
      s12_tag_r <= tag12;
      // S13: magnitudes for the divider
      s13_an_r  <= s12_num_r[63] ? (64'd0 - s12_num_r) : s12_num_r;
      s13_ad_r  <= den13[31] ? (32'd0 - den13) : den13;
      s13_tag_r <= tag13;
    end
  end

  // ---------------- divider ----------------
  logic                      dq_vld;
  logic [bptc_pkg::NumW-1:0] dq_quo;
  bptc_pkg::tag_t            dq_tag;

  bptc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fv_r[13]),
    .in_num  (s13_an_r),
    .in_den  (s13_ad_r),
    .in_tag  (s13_tag_r),
    .out_vld (dq_vld),
    .out_quo (dq_quo),
    .out_tag (dq_tag)
  );

  // ---------------- back stages ----------------
  logic [19:14] bv_r;

  logic [63:0]        s14_p_r;
  bptc_pkg::tag_t     s14_tag_r;
  logic [63:0]        s15_sll_r;
  logic [31:0]        s15_slh_r;
  logic signed [48:0] s15_8l_r;
  logic [31:0]        s15_8h_r;
  logic [63:0]        s15_p_r;
  bptc_pkg::tag_t     s15_tag_r;
  logic [63:0]        s16_ss_r, s16_b8_r, s16_p_r;
  bptc_pkg::tag_t     s16_tag_r;
  logic signed [48:0] s17_yl_r;
  logic [31:0]        s17_yh_r;
  logic [63:0]        s17_bb_r, s17_p_r;
  bptc_pkg::tag_t     s17_tag_r;
  logic [63:0]        s18_y_r, s18_bb_r, s18_p_r;
  bptc_pkg::tag_t     s18_tag_r;
  logic [63:0]        s19_x_r;
  bptc_pkg::tag_t     s19_tag_r;

  logic [63:0] s15_s;
  logic [31:0] pres20;
  assign s15_s  = 64'($signed(s14_p_r[63:13]));
  assign pres20 = s19_x_r[39:8] + (32'(p7) << 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[18:14], dq_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S14: restore quotient sign
      s14_p_r   <= dq_tag.neg ? (64'd0 - dq_quo) : dq_quo;
      s14_tag_r <= dq_tag;
      // S15: (p>>13)^2 and P8*p, split in halves
      s15_sll_r <= s15_s[31:0] * s15_s[31:0];
      s15_slh_r <= 32'(s15_s[31:0] * s15_s[63:32]);
      s15_8l_r  <= $signed({1'b0, s14_p_r[31:0]}) * p8;
      s15_8h_r  <= 32'(s14_p_r[63:32] * p8x);
      s15_p_r   <= s14_p_r;
      s15_tag_r <= s14_tag_r;
      // S16
      s16_ss_r  <= s15_sll_r + {s15_slh_r[30:0], 33'b0};
      s16_b8_r  <= 64'(s15_8l_r) + {s15_8h_r, 32'b0};
      s16_p_r   <= s15_p_r;
      s16_tag_r <= s15_tag_r;
      // S17: P9 * square halves
      s17_yl_r  <= $signed({1'b0, s16_ss_r[31:0]}) * p9;
      s17_yh_r  <= 32'(s16_ss_r[63:32] * p9x);
      s17_bb_r  <= 64'($signed(s16_b8_r[63:19]));
      s17_p_r   <= s16_p_r;
      s17_tag_r <= s16_tag_r;
      // S18
      s18_y_r   <= 64'(s17_yl_r) + {s17_yh_r, 32'b0};
      s18_bb_r  <= s17_bb_r;
      s18_p_r   <= s17_p_r;
      s18_tag_r <= s17_tag_r;
      // S19
      s19_x_r   <= s18_p_r + 64'($signed(s18_y_r[63:25])) + s18_bb_r;
      s19_tag_r <= s18_tag_r;
    end
  end

  // ---------------- output register ----------------
  logic [31:0]        out_pres_r;
  logic signed [14:0] out_temp_r;
  logic signed [31:0] out_fine_r;
  logic               out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= bv_r[19];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pres_r <= s19_tag_r.err ? 32'd0 : pres20;
      out_temp_r <= s19_tag_r.temp;
      out_fine_r <= s19_tag_r.fine;
      out_err_r  <= s19_tag_r.err;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_pres_r, out_fine_r, out_temp_r};
  assign out_tuser  = out_err_r;

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[78:47] == 32'd0))
    else $error("divide error with nonzero pressure");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[14:0]) >= -15'sd4000) &&
                    ($signed(out_tdata[14:0]) <= 15'sd8500)))
    else $error("temperature outside saturation range");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && (fv_r == '0) && (bv_r == '0)))
    else $error("pipeline not empty after reset");

endmodule
